[rtl/ffpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg
// Status codes, operation codes and page geometry shared by the first-fit
// page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
	localparam logic [2:0] ST_TOO_BIG    = 3'd2;
	localparam logic [2:0] ST_NO_SPACE   = 3'd3;
	localparam logic [2:0] ST_ALLOC_FULL = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
	localparam logic [2:0] ST_FREE_FULL  = 3'd6;

	// Size of the managed page; the offset and size ports are sized for it.
	localparam int PAGE_BYTES = 4096;

	// Request sizes must be a multiple of 2**ALIGN_BITS bytes; this many low bits must be zero.
	localparam int ALIGN_BITS = 3;
endpackage
`default_nettype wire

[rtl/first_fit_page_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit allocator over one page with compacted free and used chunk tables.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done high, and the receiver cannot
// stall it. Both tables live in synchronous simple dual-port memories with a
// registered read, so a request walks its table one entry per cycle and, when
// an entry is removed, compacts it by moving each later entry down one place
// through S_SHIFT, S_SHWR and S_FRD. A rejected size goes straight to S_DONE,
// which raises done. A new request can be taken in the cycle that shows the
// result.
module first_fit_page_allocator #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         op,
	input  wire  [12:0] request_size,
	input  wire  [11:0] buffer_offset,
	output logic        done,
	output logic [11:0] granted_offset,
	output logic [2:0]  status
);
	import ffpa_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int OW = $clog2(PAGE_BYTES);
	localparam int SW = OW + 1;

	typedef logic [OW+SW-1:0] entry_t;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_SHIFT = 4'd3;
	localparam logic [3:0] S_SHWR  = 4'd4;
	localparam logic [3:0] S_DONE  = 4'd5;
	localparam logic [3:0] S_FRD   = 4'd6;

	// Table memories.
	entry_t free_mem [TABLE_ENTRIES];
	entry_t used_mem [TABLE_ENTRIES];

	logic [3:0]    state_q;
	logic          op_q;
	logic [SW-1:0] req_q;
	logic [OW-1:0] off_q;
	logic [CW-1:0] free_cnt_q, used_cnt_q;
	logic          free_init_q;     // entry 0 of free table not yet written
	logic [CW-1:0] idx_q;           // address in flight
	logic [CW-1:0] lim_q;
	entry_t        frd_q, urd_q;
	logic [11:0]   gr_q;
	logic [2:0]    st_q;

	// Memory ports.
	logic          f_we, u_we;
	logic [IW-1:0] f_wa, u_wa, f_ra, u_ra;
	entry_t        f_wd, u_wd;

	always_ff @(posedge clk) begin
		if (f_we) free_mem[f_wa] <= f_wd;
		if (u_we) used_mem[u_wa] <= u_wd;
		frd_q <= free_mem[f_ra];
		urd_q <= used_mem[u_ra];
	end

	// Entry 0 of the free table reads as the whole page until first written.
	entry_t        f_ent;
	logic          f_rd0_q;
	logic [OW-1:0] f_off;
	logic [SW-1:0] f_sz;
	logic [OW-1:0] u_off;
	always_comb begin
		f_ent = (f_rd0_q && free_init_q) ? {{OW{1'b0}}, SW'(PAGE_BYTES)} : frd_q;
		{f_off, f_sz} = f_ent;
		u_off = urd_q[OW+SW-1:SW];
	end

	logic [SW-1:0] req_in;
	logic          bad_size, too_big;
	assign req_in   = SW'(request_size);
	assign bad_size = (request_size == 13'd0) || (request_size[ALIGN_BITS-1:0] != '0);
	assign too_big  = (32'(request_size) > PAGE_BYTES);
	assign busy     = (state_q != S_IDLE);

	logic scan_end;
	assign scan_end = (idx_q == lim_q);

	// Combinational memory control.
	always_comb begin
		f_we = 1'b0; u_we = 1'b0;
		f_wa = idx_q[IW-1:0]; u_wa = idx_q[IW-1:0];
		f_wd = f_ent; u_wd = urd_q;
		f_ra = idx_q[IW-1:0]; u_ra = idx_q[IW-1:0];
		case (state_q)
			S_SCAN: begin
				if (!op_q && idx_q != '0 && f_sz >= req_q) begin
					// Split: keep the high part in place.
					if (f_sz != req_q && used_cnt_q != CW'(TABLE_ENTRIES)) begin
						f_we = 1'b1;
						f_wa = IW'(idx_q - 1'b1);
						f_wd = {f_off + OW'(req_q), f_sz - req_q};
					end
					if (used_cnt_q != CW'(TABLE_ENTRIES)) begin
						u_we = 1'b1;
						u_wa = used_cnt_q[IW-1:0];
						u_wd = {f_off, req_q};
					end
				end else if (op_q && idx_q != '0 && u_off == off_q
						&& free_cnt_q != CW'(TABLE_ENTRIES)) begin
					f_we = 1'b1;
					f_wa = free_cnt_q[IW-1:0];
					f_wd = urd_q;
				end
			end
			S_SHWR: begin
				// Move entry idx down to idx-1.
				if (op_q) begin
					u_we = 1'b1;
					u_wa = IW'(idx_q - 1'b1);
					u_wd = urd_q;
				end else begin
					f_we = 1'b1;
					f_wa = IW'(idx_q - 1'b1);
					f_wd = f_ent;
				end
			end
			default: ;
		endcase
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_cnt_q  <= CW'(1);
			used_cnt_q  <= '0;
			free_init_q <= 1'b1;
			done        <= 1'b0;
			idx_q       <= '0;
			f_rd0_q     <= 1'b0;
			op_q        <= OP_ALLOC;
			req_q       <= '0;
			off_q       <= '0;
			gr_q        <= '0;
			st_q        <= ST_OK;
			lim_q       <= '0;
		end else begin
			done    <= 1'b0;
			f_rd0_q <= (f_ra == '0);
			if (f_we && f_wa == '0) free_init_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= op;
						req_q <= req_in;
						off_q <= OW'(buffer_offset);
						gr_q  <= '0;
						idx_q <= '0;
						lim_q <= op ? used_cnt_q : free_cnt_q;
						if (op == OP_ALLOC && bad_size) begin
							st_q <= ST_BAD_SIZE; state_q <= S_DONE;
						end else if (op == OP_ALLOC && too_big) begin
							st_q <= ST_TOO_BIG; state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// idx_q-1 is the entry whose read data is now present.
					if (idx_q != '0 && !op_q && f_sz >= req_q) begin
						if (used_cnt_q == CW'(TABLE_ENTRIES)) begin
							st_q <= ST_ALLOC_FULL; state_q <= S_DONE;
						end else begin
							st_q <= ST_OK; gr_q <= 12'(f_off);
							used_cnt_q <= used_cnt_q + 1'b1;
							if (f_sz != req_q) begin
								state_q <= S_DONE;
							end else begin
								free_cnt_q <= free_cnt_q - 1'b1;
								state_q    <= S_SHIFT;
							end
						end
					end else if (idx_q != '0 && op_q && u_off == off_q) begin
						if (free_cnt_q == CW'(TABLE_ENTRIES)) begin
							st_q <= ST_FREE_FULL; state_q <= S_DONE;
						end else begin
							st_q <= ST_OK;
							free_cnt_q <= free_cnt_q + 1'b1;
							used_cnt_q <= used_cnt_q - 1'b1;
							state_q    <= S_SHIFT;
						end
					end else if (scan_end) begin
						st_q    <= op_q ? ST_NOT_FOUND : ST_NO_SPACE;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SHIFT: begin
					// idx_q is one past the removed entry; read it if valid.
					if (idx_q == lim_q) state_q <= S_DONE;
					else state_q <= S_SHWR;
				end
				S_SHWR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_SHIFT;
				end
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result registers drive the result ports directly.
	assign granted_offset = gr_q;
	assign status         = st_q;
endmodule
`default_nettype wire
